// ===== rtl/srpa_pkg.sv =====
package srpa_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int MIN_SAMPLES_DEF   = 10;

    // Widest sample the job record carries, plus one bit for a rise
    localparam int SAMPLE_WIDTH_MAX = 24;
    localparam int VAL_W            = SAMPLE_WIDTH_MAX + 1;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_PERIOD   = 8'd0,
        CFG_STEP_MAGNITUDE  = 8'd1,
        CFG_CONTROLLER_TYPE = 8'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FEW       = 3'd1,
        ST_ZERO_STEP = 3'd2,
        ST_NO_RISE   = 3'd3,
        ST_BAD_GAIN  = 3'd4
    } t_status;

    // One finished step response, handed from the front to the back
    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  first;
        logic signed [VAL_W-1:0]  last;
        logic signed [VAL_W-1:0]  peak;
        logic signed [VAL_W-1:0]  rise;
        logic [31:0]              stamp;
        logic [31:0]              ts;
        logic [30:0]              step;
        logic [1:0]               ctype;
    } t_job;

    // Round a factor in thousandths to the fixed-point format
    function automatic logic [63:0] f_qconst(input logic [63:0] milli, input int fb);
        return ((milli << fb) + 64'd500) / 64'd1000;
    endfunction

    // Saturate to signed 32 bits
    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/srpa_if.sv =====
interface srpa_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
    logic [31:0]                    sample_time;
    logic                           last_sample;

    modport source (output valid, sample_value, sample_time, last_sample, input ready);
    modport sink (input valid, sample_value, sample_time, last_sample, output ready);
endinterface

interface srpa_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] model_gain;
    logic signed [31:0] lag_constant;
    logic signed [31:0] dead_time;
    logic signed [31:0] proportional_gain;
    logic signed [31:0] integral_time;
    logic signed [31:0] derivative_time;
    logic signed [31:0] integral_gain;
    logic signed [31:0] derivative_gain;

    modport source (output valid, status, model_gain, lag_constant, dead_time,
        proportional_gain, integral_time, derivative_time, integral_gain,
        derivative_gain, input ready);
    modport sink (input valid, status, model_gain, lag_constant, dead_time,
        proportional_gain, integral_time, derivative_time, integral_gain,
        derivative_gain, output ready);
endinterface

interface srpa_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/step_response_pid_autotune_unit.sv =====
// Step-response PID autotuner. Samples of a plant's step response come in one
// per cycle with their time stamps; the front end tracks the first sample, the
// largest rise between neighbors (earliest kept on ties) and where it
// happened, and never stalls while the job queue has room. A sample marked
// last closes the run and queues it; the next run's samples are taken at once.
// The back end then fits gain, time constant and dead time by the tangent
// method and applies the P, PI, PD or PID tuning row, all in signed fixed
// point with FRACTION_BITS fraction bits and saturation to 32 bits. A run that
// fails its sample count, step or rise check goes from S_IDLE straight to S_OUT
// with no fit; a nonpositive gain ends the run after the dead-time, time-constant
// and gain fits, and a full PID tune runs up to six divisions on a shared radix-2
// divider. The queue holds two closed runs; with both waiting, sample input
// stalls until the back end frees a slot. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
module step_response_pid_autotune_unit #(
    parameter int SAMPLE_WIDTH  = srpa_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = srpa_pkg::FRACTION_BITS_DEF,
    parameter int COUNT_WIDTH   = srpa_pkg::COUNT_WIDTH_DEF,
    parameter int MIN_SAMPLES   = srpa_pkg::MIN_SAMPLES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srpa_sample_if.sink   i_sample,
    srpa_cfg_if.sink      i_cfg,
    srpa_result_if.source o_result
);
    import srpa_pkg::*;

    t_job job_in;
    t_job job_out;
    logic push;
    logic pop;
    logic full;
    logic q_valid;

    srpa_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .MIN_SAMPLES  (MIN_SAMPLES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_cfg    (i_cfg),
        .i_full   (full),
        .o_push   (push),
        .o_job    (job_in)
    );

    srpa_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (job_out),
        .i_pop   (pop)
    );

    srpa_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (job_out),
        .o_pop    (pop),
        .o_result (o_result)
    );
endmodule

// ===== rtl/srpa_div.sv =====
module srpa_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_dividend,
    input  logic [63:0]        i_divisor,
    output logic               o_done,
    output logic signed [63:0] o_quot
);
    import srpa_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [64:0] r_rem;
    logic [63:0] r_dvd;
    logic [63:0] r_dvs;
    logic        r_neg;
    logic [64:0] trial;
    logic        fits;

    // One quotient bit per cycle, restoring
    always_comb begin
        trial = {r_rem[63:0], r_dvd[63]};
        fits  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitude in, sign applied at the end
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[63];
            r_dvd <= i_dividend[63] ? 64'(-i_dividend) : i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_dvs}) : trial;
            r_dvd <= {r_dvd[62:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -signed'(r_dvd) : signed'(r_dvd);
endmodule

// ===== rtl/srpa_fifo.sv =====
module srpa_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  srpa_pkg::t_job  i_job,
    output logic            o_full,
    output logic            o_valid,
    output srpa_pkg::t_job  o_job,
    input  logic            i_pop
);
    import srpa_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [PW:0]    r_cnt;

    // Track fill level and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    // Hold queued jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
endmodule

// ===== rtl/srpa_front.sv =====
module srpa_front #(
    parameter int SAMPLE_WIDTH = srpa_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = srpa_pkg::COUNT_WIDTH_DEF,
    parameter int MIN_SAMPLES  = srpa_pkg::MIN_SAMPLES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    srpa_sample_if.sink     i_sample,
    srpa_cfg_if.sink        i_cfg,
    input  logic            i_full,
    output logic            o_push,
    output srpa_pkg::t_job  o_job
);
    import srpa_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    logic [31:0]             r_ts;
    logic [30:0]             r_step;
    logic [1:0]              r_ctype;
    logic signed [SW-1:0]    r_first;
    logic signed [SW-1:0]    r_prev;
    logic signed [SW:0]      r_best;
    logic signed [SW-1:0]    r_peak;
    logic [31:0]             r_stamp;
    logic [COUNT_WIDTH-1:0]  r_cnt;

    logic signed [SW-1:0]    v;
    logic signed [SW:0]      rise;
    logic                    upd;
    logic                    accept;
    logic signed [SW-1:0]    n_first;
    logic signed [SW:0]      n_best;
    logic signed [SW-1:0]    n_peak;
    logic [31:0]             n_stamp;
    logic [COUNT_WIDTH-1:0]  n_cnt;
    t_status                 cls;

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = !i_full;
    assign accept         = i_sample.valid && !i_full;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts    <= 32'h0001_0000;
            r_step  <= 31'h0001_0000;
            r_ctype <= 2'd3;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SAMPLE_PERIOD:   r_ts    <= i_cfg.data;
                CFG_STEP_MAGNITUDE:  r_step  <= i_cfg.data[30:0];
                CFG_CONTROLLER_TYPE: r_ctype <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    // Track first sample and the largest rise; earliest wins on ties
    always_comb begin
        v       = i_sample.sample_value;
        rise    = (SW+1)'(v) - (SW+1)'(r_prev);
        upd     = (r_cnt != '0) && (rise > r_best);
        n_first = (r_cnt == '0) ? v : r_first;
        n_best  = upd ? rise : r_best;
        n_peak  = upd ? v : r_peak;
        n_stamp = upd ? i_sample.sample_time : r_stamp;
        n_cnt   = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;

        // Classify the run on its last sample
        if (33'(n_cnt) < 33'(MIN_SAMPLES)) begin
            cls = ST_FEW;
        end else if (r_step == '0) begin
            cls = ST_ZERO_STEP;
        end else if (n_best <= 0) begin
            cls = ST_NO_RISE;
        end else begin
            cls = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_prev  <= '0;
            r_best  <= '0;
            r_peak  <= '0;
            r_stamp <= '0;
            r_cnt   <= '0;
        end else if (accept) begin
            if (i_sample.last_sample) begin
                r_first <= '0;
                r_prev  <= '0;
                r_best  <= '0;
                r_peak  <= '0;
                r_stamp <= '0;
                r_cnt   <= '0;
            end else begin
                r_first <= n_first;
                r_prev  <= v;
                r_best  <= n_best;
                r_peak  <= n_peak;
                r_stamp <= n_stamp;
                r_cnt   <= n_cnt;
            end
        end
    end

    // Build the job for the back end
    always_comb begin
        o_push       = accept && i_sample.last_sample;
        o_job.status = cls;
        o_job.first  = VAL_W'(n_first);
        o_job.last   = VAL_W'(v);
        o_job.peak   = VAL_W'(n_peak);
        o_job.rise   = VAL_W'(n_best);
        o_job.stamp  = n_stamp;
        o_job.ts     = r_ts;
        o_job.step   = r_step;
        o_job.ctype  = r_ctype;
    end
endmodule

// ===== rtl/srpa_back.sv =====
module srpa_back #(
    parameter int FRACTION_BITS = srpa_pkg::FRACTION_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  srpa_pkg::t_job  i_job,
    output logic            o_pop,
    srpa_result_if.source   o_result
);
    import srpa_pkg::*;

    localparam int FB = FRACTION_BITS;
    localparam logic [63:0] KP_Q [4] = '{f_qconst(64'd1000, FB), f_qconst(64'd900, FB),
                                         f_qconst(64'd800, FB), f_qconst(64'd1200, FB)};
    localparam logic [63:0] TI_Q [4] = '{64'd0, f_qconst(64'd3333, FB),
                                         64'd0, f_qconst(64'd2000, FB)};
    localparam logic [63:0] TD_Q [4] = '{64'd0, 64'd0,
                                         f_qconst(64'd330, FB), f_qconst(64'd500, FB)};
    localparam logic signed [31:0] ONE = 32'sd1 <<< FB;

    typedef enum logic [21:0] {
        S_IDLE    = 22'd1 << 0,
        S_MUL_L   = 22'd1 << 1,
        S_DIV_L   = 22'd1 << 2,
        S_MUL_T   = 22'd1 << 3,
        S_DIV_T   = 22'd1 << 4,
        S_GAIN    = 22'd1 << 5,
        S_DIV_K   = 22'd1 << 6,
        S_CHK     = 22'd1 << 7,
        S_DIV_KP0 = 22'd1 << 8,
        S_MUL_A   = 22'd1 << 9,
        S_DIV_A   = 22'd1 << 10,
        S_DIV_KP  = 22'd1 << 11,
        S_MUL_TI  = 22'd1 << 12,
        S_MUL_TD  = 22'd1 << 13,
        S_TD      = 22'd1 << 14,
        S_KI      = 22'd1 << 15,
        S_DIV_KI  = 22'd1 << 16,
        S_MUL_KD  = 22'd1 << 17,
        S_KD      = 22'd1 << 18,
        S_OUT     = 22'd1 << 19,
        S_SPARE0  = 22'd1 << 20,
        S_SPARE1  = 22'd1 << 21
    } t_state;

    t_state              r_state;
    logic                r_go;
    t_job                r_job;
    t_status             r_status;
    logic signed [31:0]  r_k;
    logic signed [31:0]  r_t;
    logic signed [31:0]  r_l;
    logic signed [31:0]  r_kp;
    logic signed [31:0]  r_ti;
    logic signed [31:0]  r_td;
    logic signed [31:0]  r_ki;
    logic signed [31:0]  r_kd;
    logic [63:0]         r_a;
    logic [63:0]         r_prod;

    logic [32:0]         ts1;
    logic signed [VAL_W:0] dss;
    logic [VAL_W:0]      dss_mag;
    logic [63:0]         m_abs;
    logic [63:0]         k_lim;
    logic signed [33:0]  mul_a;
    logic signed [33:0]  mul_b;
    logic signed [67:0]  mul_p;
    logic signed [63:0]  div_dvd;
    logic [63:0]         div_dvs;
    logic                div_done;
    logic signed [63:0]  div_q;
    logic signed [63:0]  l_raw;
    logic signed [63:0]  t_raw;

    srpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // Shared operands for the multiplier and the divider
    always_comb begin
        ts1     = (r_job.ts == '0) ? 33'd1 : {1'b0, r_job.ts};
        dss     = (VAL_W+1)'(r_job.last) - (VAL_W+1)'(r_job.first);
        dss_mag = dss[VAL_W] ? (VAL_W+1)'(-dss) : (VAL_W+1)'(dss);
        m_abs   = 64'(dss_mag) << FB;
        k_lim   = 64'(r_job.step) << (31 - FB);
        l_raw   = signed'({32'd0, r_job.stamp}) - div_q;
        t_raw   = div_q - 64'(r_l);

        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL_L: begin
                mul_a = 34'((VAL_W+1)'(r_job.peak) - (VAL_W+1)'(r_job.first));
                mul_b = signed'({1'b0, ts1});
            end
            S_MUL_T: begin
                mul_a = 34'(dss);
                mul_b = signed'({1'b0, ts1});
            end
            S_MUL_A: begin
                mul_a = 34'(r_k);
                mul_b = 34'(r_l);
            end
            S_MUL_TI: begin
                mul_a = signed'(TI_Q[r_job.ctype][33:0]);
                mul_b = 34'(r_l);
            end
            S_MUL_TD: begin
                mul_a = signed'(TD_Q[r_job.ctype][33:0]);
                mul_b = 34'(r_l);
            end
            S_MUL_KD: begin
                mul_a = 34'(r_kp);
                mul_b = 34'(r_td);
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;

        div_dvd = '0;
        div_dvs = 64'd1;
        case (r_state)
            S_DIV_L, S_DIV_T: begin
                div_dvd = signed'(r_prod);
                div_dvs = 64'(unsigned'(r_job.rise));
            end
            S_DIV_K: begin
                div_dvd = signed'(m_abs << FB);
                div_dvs = 64'(r_job.step);
            end
            S_DIV_KP0: begin
                div_dvd = 64'(r_t) <<< FB;
                div_dvs = 64'({r_k, 1'b0});
            end
            S_DIV_A: begin
                div_dvd = signed'(r_prod);
                div_dvs = 64'(unsigned'(r_t));
            end
            S_DIV_KP: begin
                div_dvd = signed'(KP_Q[r_job.ctype] << FB);
                div_dvs = r_a;
            end
            S_DIV_KI: begin
                div_dvd = 64'(r_kp) <<< FB;
                div_dvs = 64'(unsigned'(r_ti));
            end
            default: ;
        endcase
    end

    // Register each product
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[63:0];
    end

    // Sequence the model fit and the tuning rules
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= (i_job.status == ST_OK) ? S_MUL_L : S_OUT;
                    end
                end
                S_MUL_L: begin
                    r_state <= S_DIV_L;
                    r_go    <= 1'b1;
                end
                S_DIV_L: begin
                    if (div_done) begin
                        r_state <= S_MUL_T;
                    end
                end
                S_MUL_T: begin
                    r_state <= S_DIV_T;
                    r_go    <= 1'b1;
                end
                S_DIV_T: begin
                    if (div_done) begin
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    if (m_abs >= k_lim) begin
                        r_state <= S_CHK;
                    end else begin
                        r_state <= S_DIV_K;
                        r_go    <= 1'b1;
                    end
                end
                S_DIV_K: begin
                    if (div_done) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_k <= 0) begin
                        r_state <= S_OUT;
                    end else if (r_l == 0) begin
                        r_state <= S_DIV_KP0;
                        r_go    <= 1'b1;
                    end else begin
                        r_state <= S_MUL_A;
                    end
                end
                S_DIV_KP0: begin
                    if (div_done) begin
                        r_state <= S_KI;
                    end
                end
                S_MUL_A: begin
                    r_state <= S_DIV_A;
                    r_go    <= 1'b1;
                end
                S_DIV_A: begin
                    if (div_done) begin
                        if (div_q == 0) begin
                            r_state <= S_KI;
                        end else begin
                            r_state <= S_DIV_KP;
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_DIV_KP: begin
                    if (div_done) begin
                        r_state <= S_MUL_TI;
                    end
                end
                S_MUL_TI: r_state <= S_MUL_TD;
                S_MUL_TD: r_state <= S_TD;
                S_TD:     r_state <= S_KI;
                S_KI: begin
                    if (r_ti > 0) begin
                        r_state <= S_DIV_KI;
                        r_go    <= 1'b1;
                    end else begin
                        r_state <= S_MUL_KD;
                    end
                end
                S_DIV_KI: begin
                    if (div_done) begin
                        r_state <= S_MUL_KD;
                    end
                end
                S_MUL_KD: r_state <= S_KD;
                S_KD:     r_state <= S_OUT;
                S_OUT: begin
                    if (o_result.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job    <= i_job;
                r_status <= i_job.status;
                r_k      <= '0;
                r_t      <= '0;
                r_l      <= '0;
                r_kp     <= '0;
                r_ti     <= '0;
                r_td     <= '0;
                r_ki     <= '0;
                r_kd     <= '0;
            end
            S_DIV_L: begin
                if (div_done) begin
                    r_l <= (l_raw < 0) ? 32'sd0 : f_sat32(l_raw);
                end
            end
            S_DIV_T: begin
                if (div_done) begin
                    r_t <= f_sat32((t_raw <= 0) ? signed'(64'(ts1)) : t_raw);
                end
            end
            S_GAIN: begin
                r_k <= dss[VAL_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
            S_DIV_K: begin
                if (div_done) begin
                    r_k <= dss[VAL_W] ? -div_q[31:0] : div_q[31:0];
                end
            end
            S_CHK: begin
                if (r_k <= 0) begin
                    r_status <= ST_BAD_GAIN;
                end
            end
            S_DIV_KP0: begin
                if (div_done) begin
                    r_kp <= f_sat32(div_q);
                    r_ti <= r_t;
                end
            end
            S_DIV_A: begin
                if (div_done) begin
                    r_a <= div_q;
                    if (div_q == 0) begin
                        r_kp <= ONE;
                        r_ti <= ONE;
                    end
                end
            end
            S_DIV_KP: begin
                if (div_done) begin
                    r_kp <= f_sat32(div_q);
                end
            end
            S_MUL_TD: r_ti <= f_sat32(signed'(r_prod >> FB));
            S_TD:     r_td <= f_sat32(signed'(r_prod >> FB));
            S_DIV_KI: begin
                if (div_done) begin
                    r_ki <= f_sat32(div_q);
                end
            end
            S_KD:     r_kd <= f_sat32(signed'(r_prod >> FB));
            default: ;
        endcase
    end

    assign o_pop = (r_state == S_IDLE) && i_valid;

    // Drive the result channel from the held registers
    always_comb begin
        o_result.valid             = (r_state == S_OUT);
        o_result.status            = r_status;
        o_result.model_gain        = r_k;
        o_result.lag_constant      = r_t;
        o_result.dead_time         = r_l;
        o_result.proportional_gain = r_kp;
        o_result.integral_time     = r_ti;
        o_result.derivative_time   = r_td;
        o_result.integral_gain     = r_ki;
        o_result.derivative_gain   = r_kd;
    end
endmodule

// ===== sim/tb_step_response_pid_autotune_unit.sv =====
`timescale 1ns / 1ps

module tb_step_response_pid_autotune_unit;
    import srpa_pkg::*;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  SETTLE_CYCLES  = 600;
    localparam int  COUNT_MAX      = (1 << COUNT_WIDTH_DEF) - 1;
    localparam logic [7:0] CFG_UNUSED_INDEX = 8'hff;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct {
        logic [2:0] status;
        longint     field[8];
    } tune_t;

    logic i_clk;
    logic i_rst_n;

    srpa_sample_if #(.SAMPLE_WIDTH(16)) smp ();
    srpa_cfg_if                         cfg ();
    srpa_result_if                      res ();

    step_response_pid_autotune_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp.sink),
        .i_cfg    (cfg.sink),
        .o_result (res.source)
    );

    // Predictor copy of configuration and tracking state
    longint unsigned per_q, step_q;
    logic [1:0]      ctype_q;
    longint          first_v, prev_v, best_rise, peak_v, peak_t;
    int              seen;

    tune_t tune_q[$];
    int    errors;
    int    src_idle;
    int    snk_stall;
    int    idle_cnt;
    string field_names[8] = '{"model_gain", "lag_constant", "dead_time",
        "proportional_gain", "integral_time", "derivative_time",
        "integral_gain", "derivative_gain"};

    // Generate clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint clip32(input longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    function automatic longint round_q(input longint milli);
        return ((milli << 16) + 500) / 1000;
    endfunction

    // Track one accepted sample; on the last one work out the tuning
    function automatic void track_sample(input logic signed [15:0] sv, input logic [31:0] st,
                                         input bit last);
        longint v, t, ts, dss, lt, tc, kg, m, a, kp, ti, td, ki, kd;
        longint kpf, tif, tdf;
        tune_t  r;
        v = sv;
        t = longint'({32'b0, st});
        r.status = ST_OK;
        for (int i = 0; i < 8; i++) r.field[i] = 0;
        if (seen == 0) begin
            first_v = v;
        end else if (v - prev_v > best_rise) begin
            best_rise = v - prev_v;
            peak_v    = v;
            peak_t    = t;
        end
        prev_v = v;
        if (seen < COUNT_MAX) seen++;
        if (!last) return;

        if (seen < MIN_SAMPLES_DEF) begin
            r.status = ST_FEW;
        end else if (step_q == 0) begin
            r.status = ST_ZERO_STEP;
        end else if (best_rise <= 0) begin
            r.status = ST_NO_RISE;
        end else begin
            ts  = (per_q == 0) ? 1 : longint'(per_q);
            dss = v - first_v;
            lt  = peak_t - ((peak_v - first_v) * ts) / best_rise;
            if (lt < 0) lt = 0;
            lt = clip32(lt);
            tc = (dss * ts) / best_rise - lt;
            if (tc <= 0) tc = ts;
            tc = clip32(tc);
            m = (dss < 0 ? -dss : dss) << 16;
            if (m >= (longint'(step_q) << 15)) begin
                kg = (dss < 0) ? SAT_LO : SAT_HI;
            end else begin
                kg = (m << 16) / longint'(step_q);
                if (dss < 0) kg = -kg;
            end
            r.field[0] = kg;
            r.field[1] = tc;
            r.field[2] = lt;
            if (kg <= 0) begin
                r.status = ST_BAD_GAIN;
            end else begin
                case (ctype_q)
                    2'd0: begin kpf = 1000; tif = 0;    tdf = 0;   end
                    2'd1: begin kpf = 900;  tif = 3333; tdf = 0;   end
                    2'd2: begin kpf = 800;  tif = 0;    tdf = 330; end
                    default: begin kpf = 1200; tif = 2000; tdf = 500; end
                endcase
                if (lt == 0) begin
                    kp = clip32((tc << 16) / (2 * kg));
                    ti = tc;
                    td = 0;
                end else begin
                    a = (kg * lt) / tc;
                    if (a == 0) begin
                        kp = 1 << 16;
                        ti = 1 << 16;
                        td = 0;
                    end else begin
                        kp = clip32((round_q(kpf) << 16) / a);
                        ti = clip32((round_q(tif) * lt) >>> 16);
                        td = clip32((round_q(tdf) * lt) >>> 16);
                    end
                end
                ki = (ti > 0) ? clip32((kp << 16) / ti) : 0;
                kd = clip32((kp * td) >>> 16);
                r.field[3] = kp;
                r.field[4] = ti;
                r.field[5] = td;
                r.field[6] = ki;
                r.field[7] = kd;
            end
        end
        tune_q.push_back(r);
        first_v   = 0;
        prev_v    = 0;
        best_rise = 0;
        peak_v    = 0;
        peak_t    = 0;
        seen      = 0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Send one sample request, idling at random first
    task automatic send_sample(input logic [15:0] v, input logic [31:0] t, input bit last);
        while ($urandom_range(99) < src_idle) begin
            smp.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp.valid        <= 1'b1;
        smp.sample_value <= v;
        smp.sample_time  <= t;
        smp.last_sample  <= last;
        forever begin
            @(negedge i_clk);
            if (smp.ready) begin
                track_sample(v, t, last);
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
    endtask

    // Drop valid, then hold until every expected result has come and the block settles
    task automatic wait_idle();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (tune_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        forever begin
            @(negedge i_clk);
            if (cfg.ready) begin
                if (idx == CFG_SAMPLE_PERIOD) per_q = data;
                else if (idx == CFG_STEP_MAGNITUDE) step_q = data[30:0];
                else if (idx == CFG_CONTROLLER_TYPE) ctype_q = data[1:0];
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pick a setting, extremes often
    task automatic pick_config();
        logic [31:0] p, s;
        case ($urandom_range(5))
            0: p = 32'd0;
            1: p = 32'd1;
            2: p = 32'hffff_ffff;
            3: p = 32'h0001_0000;
            default: p = $urandom_range(16, 1 << 20);
        endcase
        case ($urandom_range(9))
            0: s = 32'd0;
            1: s = 32'd1;
            2: s = 32'h7fff_ffff;
            3: s = 32'hffff_ffff;
            4: s = 32'h0001_0000;
            default: s = $urandom_range(1, 1 << 22);
        endcase
        write_reg(CFG_SAMPLE_PERIOD, p);
        write_reg(CFG_STEP_MAGNITUDE, s);
        write_reg(CFG_CONTROLLER_TYPE, $urandom);
        if ($urandom_range(3) == 0) write_reg(CFG_UNUSED_INDEX, $urandom);
    endtask

    // Send one response: clean step, falling step or pure noise
    task automatic send_response(input int n, input int shape);
        int          base, amp, dly, rlen, y, k;
        logic [31:0] t, tstep;
        base  = $urandom_range(0, 4000) - 2000;
        amp   = $urandom_range(1, 20000);
        dly   = $urandom_range(0, n / 2);
        rlen  = $urandom_range(1, n);
        tstep = (per_q == 0) ? 32'd1 : per_q[31:0];
        if ($urandom_range(3) == 0) tstep = $urandom;
        t = $urandom_range(0, 3) == 0 ? $urandom : 32'd0;
        if (shape == 2) amp = -amp;
        for (int i = 0; i < n; i++) begin
            if (shape == 1) begin
                y = $urandom_range(0, 65535) - 32768;
                t = $urandom;
            end else begin
                k = (i < dly) ? 0 : ((i - dly < rlen) ? i - dly : rlen);
                y = base + (amp * k) / rlen + int'($urandom_range(0, 4)) - 2;
                if (y > 32767) y = 32767;
                if (y < -32768) y = -32768;
            end
            send_sample(y[15:0], t, i == n - 1);
            t = t + tstep;
        end
    endtask

    task automatic test_directed();
        pick_config();
        send_sample(16'h7fff, 32'hffff_ffff, 1'b1);
        for (int i = 0; i < 10; i++) send_sample(16'h8000, 32'(i), i == 9);
        wait_idle();
        write_reg(CFG_STEP_MAGNITUDE, 32'd0);
        for (int i = 0; i < 10; i++) send_sample(16'(i * 100), 32'(i << 16), i == 9);
        wait_idle();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int items);
        int sent, n, shape, pick;
        src_idle  = idle_pct;
        snk_stall = stall_pct;
        sent      = 0;
        while (sent < items) begin
            wait_idle();
            pick_config();
            for (int r = 0; r < 3; r++) begin
                n    = ($urandom_range(7) == 0) ? $urandom_range(1, 9) : $urandom_range(10, 40);
                pick = $urandom_range(19);
                shape = (pick < 15) ? 0 : (pick < 17) ? 2 : 1;
                send_response(n, shape);
                sent += n;
            end
        end
        wait_idle();
    endtask

    // Stall results at random
    always @(posedge i_clk) begin
        res.ready <= ($urandom_range(99) >= snk_stall);
    end

    // Check each accepted result against the oldest expectation
    always @(negedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (tune_q.size() == 0) begin
                report_mismatch("result with no expectation");
            end else begin
                tune_t e;
                logic [31:0] got[8];
                e = tune_q.pop_front();
                got = '{res.model_gain, res.lag_constant, res.dead_time,
                    res.proportional_gain, res.integral_time, res.derivative_time,
                    res.integral_gain, res.derivative_gain};
                if (res.status !== e.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                        res.status, e.status));
                for (int i = 0; i < 8; i++)
                    if (got[i] !== e.field[i][31:0])
                        report_mismatch($sformatf("%s got %h want %h", field_names[i],
                            got[i], e.field[i][31:0]));
            end
        end
    end

    // End the run when nothing is accepted for too long
    always @(negedge i_clk) begin
        if ((smp.valid && smp.ready) || (cfg.valid && cfg.ready) || (res.valid && res.ready))
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("step_response_pid_autotune_unit regression: fail");
            $finish;
        end
    end

    initial begin
        errors    = 0;
        idle_cnt  = 0;
        src_idle  = 0;
        snk_stall = 0;
        per_q     = 65536;
        step_q    = 65536;
        ctype_q   = 2'd3;
        first_v   = 0;
        prev_v    = 0;
        best_rise = 0;
        peak_v    = 0;
        peak_t    = 0;
        seen      = 0;
        i_rst_n          = 1'b0;
        smp.valid        = 1'b0;
        smp.sample_value = '0;
        smp.sample_time  = '0;
        smp.last_sample  = 1'b0;
        cfg.valid        = 1'b0;
        cfg.index        = '0;
        cfg.data         = '0;
        res.ready        = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(0, 0, 260);
        test_random_phase(67, 0, 260);
        test_random_phase(0, 67, 260);
        test_random_phase(38, 38, 260);

        wait_idle();
        if (errors == 0)
            $display("step_response_pid_autotune_unit regression: pass");
        else
            $display("step_response_pid_autotune_unit regression: fail");
        $finish;
    end

endmodule

// ===== step_response_pid_autotune_unit.f =====
rtl/srpa_pkg.sv
rtl/srpa_if.sv
rtl/srpa_div.sv
rtl/srpa_fifo.sv
rtl/srpa_front.sv
rtl/srpa_back.sv
rtl/step_response_pid_autotune_unit.sv
sim/tb_step_response_pid_autotune_unit.sv
